// File: rtl/core/nrfc_pkg.sv
// Shared types and constants of the NFC response frame checker.
// No dependencies; imported by every module of the block.
package nrfc_pkg;

   // Fixed frame bytes
   localparam logic [7:0] READY_BYTE    = 8'h01;
   localparam logic [7:0] ZERO_BYTE     = 8'h00;
   localparam logic [7:0] START_BYTE    = 8'hFF;
   localparam logic [7:0] DIR_BYTE      = 8'hD5;
   localparam logic [7:0] ACK_LAST_POS  = 8'd6;

   // Byte positions inside an information frame
   localparam logic [8:0] POS_PRE_A     = 9'd1;
   localparam logic [8:0] POS_PRE_B     = 9'd2;
   localparam logic [8:0] POS_START     = 9'd3;
   localparam logic [8:0] POS_LEN       = 9'd4;
   localparam logic [8:0] POS_LCS       = 9'd5;
   localparam logic [8:0] POS_DIR       = 9'd6;
   localparam logic [8:0] POS_CODE      = 9'd7;
   localparam logic [8:0] POS_PAYLOAD   = 9'd8;

   // Target list offsets inside the payload
   localparam logic [8:0] TG_NBTG       = 9'd0;
   localparam logic [8:0] TG_IDLEN      = 9'd5;
   localparam logic [8:0] TG_ID_START   = 9'd6;

   // Result queue geometry
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_AW    = 2;

   // Register addresses (word index)
   typedef enum logic [1:0] {
      REG_EXPECT_ACK    = 2'd0,
      REG_EXPECTED_CODE = 2'd1,
      REG_UID_ONLY      = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FRAME   = 2'd1,
      STATUS_NO_CARD = 2'd2
   } status_type;

   typedef struct packed {
      logic       expect_ack;
      logic [7:0] expected_code;
      logic       uid_only;
   } cfg_type;

   // What the checker produces for one item
   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      logic       status_valid;
      status_type status_code;
      logic [5:0] payload_count;
   } chk_out_type;

   // One result item
   typedef struct packed {
      logic       result_kind;
      logic [7:0] data_byte;
      status_type status_code;
      logic [5:0] payload_count;
      logic       is_last;
   } rsp_type;

   // Acknowledge frame after the ready byte
   function automatic logic [7:0] ack_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'h00;
         3'd1:    b = 8'h00;
         3'd2:    b = 8'hFF;
         3'd3:    b = 8'h00;
         3'd4:    b = 8'hFF;
         3'd5:    b = 8'h00;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/core/nrfc_csr.sv
// Configuration registers of the frame checker behind an APB-style port.
// Depends on nrfc_pkg.
module nrfc_csr import nrfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output cfg_type     cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign idx   = reg_index_type'(paddr[3:2]);
   assign wr_en = psel & penable & pwrite;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_EXPECT_ACK:    cfg_in.expect_ack    = pwdata[0];
            REG_EXPECTED_CODE: cfg_in.expected_code = pwdata[7:0];
            REG_UID_ONLY:      cfg_in.uid_only      = pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_EXPECT_ACK:    prdata = {31'd0, cfg_ff.expect_ack};
         REG_EXPECTED_CODE: prdata = {24'd0, cfg_ff.expected_code};
         REG_UID_ONLY:      prdata = {31'd0, cfg_ff.uid_only};
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/nrfc_check.sv
// Per-byte frame check: transaction state and the decision for one item.
// Depends on nrfc_pkg.
module nrfc_check import nrfc_pkg::*; #(
   parameter int MAX_READ_BYTES = 32,
   parameter int MAX_ID_BYTES   = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic [7:0]  rx_byte,
   input  logic        end_of_read,
   input  cfg_type     cfg,
   output chk_out_type res
);

   localparam int PW = $clog2(MAX_READ_BYTES);

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    sum_ff, sum_in;
   logic          err_ff, err_in;
   logic          done_ff, done_in;
   logic          nocard_ff, nocard_in;
   logic [3:0]    idlen_ff, idlen_in;
   logic [5:0]    cnt_ff, cnt_in;

   logic [8:0]    pos9, len9, q9;
   logic [7:0]    lcs_sum, pl;
   logic          emit;
   status_type    status;

   assign pos9 = 9'(pos_ff);
   assign len9 = {1'b0, len_ff};
   assign q9   = pos9 - POS_PAYLOAD;
   assign lcs_sum = len_ff + rx_byte;
   assign pl      = len_ff - 8'd2;

   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      err_in    = err_ff;
      done_in   = done_ff;
      nocard_in = nocard_ff;
      idlen_in  = idlen_ff;
      cnt_in    = cnt_ff;
      emit      = 1'b0;
      status    = STATUS_OK;

      // Check the byte at the current position
      if (fire && !err_ff && !done_ff) begin
         priority if (pos_ff == '0) begin
            if (rx_byte != READY_BYTE) err_in = 1'b1;
         end else if (cfg.expect_ack) begin
            if (pos9 <= 9'(ACK_LAST_POS)) begin
               if (rx_byte != ack_byte(3'(pos9 - 9'd1))) err_in = 1'b1;
               else if (pos9 == 9'(ACK_LAST_POS)) done_in = 1'b1;
            end
         end else if (pos9 == POS_PRE_A || pos9 == POS_PRE_B) begin
            if (rx_byte != ZERO_BYTE) err_in = 1'b1;
         end else if (pos9 == POS_START) begin
            if (rx_byte != START_BYTE) err_in = 1'b1;
         end else if (pos9 == POS_LEN) begin
            len_in = rx_byte;
         end else if (pos9 == POS_LCS) begin
            if (lcs_sum != 8'd0 || len_ff < 8'd2 ||
                POS_PAYLOAD + len9 > 9'(MAX_READ_BYTES)) err_in = 1'b1;
         end else if (pos9 == POS_DIR) begin
            if (rx_byte != DIR_BYTE) err_in = 1'b1;
            else sum_in = rx_byte;
         end else if (pos9 == POS_CODE) begin
            if (rx_byte != cfg.expected_code) err_in = 1'b1;
            else sum_in = sum_ff + rx_byte;
         end else if (pos9 < POS_DIR + len9) begin
            // Payload byte
            sum_in = sum_ff + rx_byte;
            if (!cfg.uid_only) begin
               emit = 1'b1;
            end else begin
               priority if (q9 == TG_NBTG) begin
                  if (rx_byte == 8'd0) nocard_in = 1'b1;
               end else if (q9 == TG_IDLEN) begin
                  if (!nocard_ff) begin
                     if (rx_byte == 8'd0 || rx_byte > 8'(MAX_ID_BYTES)) err_in = 1'b1;
                     else idlen_in = rx_byte[3:0];
                  end
               end else if (q9 >= TG_ID_START && !nocard_ff && idlen_ff != 4'd0 &&
                            q9 < TG_ID_START + 9'(idlen_ff)) begin
                  emit = 1'b1;
               end else begin
                  emit = 1'b0;
               end
            end
         end else if (pos9 == POS_DIR + len9) begin
            if (8'(sum_ff + rx_byte) != 8'd0) err_in = 1'b1;
         end else if (pos9 == POS_CODE + len9) begin
            // Postamble closes the frame
            if (rx_byte != ZERO_BYTE) begin
               err_in = 1'b1;
            end else begin
               done_in = 1'b1;
               if (cfg.uid_only) begin
                  if (pl < 8'd1) err_in = 1'b1;
                  else if (!nocard_ff) begin
                     if (pl < 8'd6 || 8'd6 + 8'(idlen_ff) > pl) err_in = 1'b1;
                  end
               end
            end
         end else begin
            // Bytes beyond the frame need no check
            err_in = err_ff;
         end
         if (emit) cnt_in = cnt_ff + 6'd1;
      end

      // Close the transaction or advance
      if (fire && end_of_read) begin
         if (err_in || !done_in) status = STATUS_FRAME;
         else if (nocard_in)     status = STATUS_NO_CARD;
         else                    status = STATUS_OK;
      end
      res.data_valid    = emit;
      res.data_byte     = rx_byte;
      res.status_valid  = fire & end_of_read;
      res.status_code   = status;
      res.payload_count = (status == STATUS_NO_CARD) ? 6'd0 : cnt_in;

      if (fire && end_of_read) begin
         pos_in    = '0;
         len_in    = '0;
         sum_in    = '0;
         err_in    = 1'b0;
         done_in   = 1'b0;
         nocard_in = 1'b0;
         idlen_in  = '0;
         cnt_in    = '0;
      end else if (fire) begin
         if ((PW+1)'(pos_ff) + (PW+1)'(1) >= (PW+1)'(MAX_READ_BYTES)) err_in = 1'b1;
         else pos_in = pos_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         len_ff    <= '0;
         sum_ff    <= '0;
         err_ff    <= 1'b0;
         done_ff   <= 1'b0;
         nocard_ff <= 1'b0;
         idlen_ff  <= '0;
         cnt_ff    <= '0;
      end else begin
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         sum_ff    <= sum_in;
         err_ff    <= err_in;
         done_ff   <= done_in;
         nocard_ff <= nocard_in;
         idlen_ff  <= idlen_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: rtl/core/nrfc_outq.sv
// Small result queue: takes up to two result items a cycle, hands out one while out_ready is high.
// Depends on nrfc_pkg.
module nrfc_outq import nrfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_cnt,
   input  rsp_type    push_a,
   input  rsp_type    push_b,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output rsp_type    out_item
);

   rsp_type              ent_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]   wr_ff, wr_in;
   logic [OUTQ_AW-1:0]   rd_ff, rd_in;
   logic [OUTQ_AW:0]     cnt_ff, cnt_in;
   logic                 pop;

   assign out_valid = (cnt_ff != '0);
   assign out_item  = ent_ff[rd_ff];
   assign pop       = out_valid & out_ready;
   // Room for the two results one item can cause
   assign room      = (cnt_ff <= (OUTQ_AW+1)'(OUTQ_DEPTH - 2));

   always_comb begin
      wr_in  = wr_ff + OUTQ_AW'(push_cnt);
      rd_in  = rd_ff + OUTQ_AW'(pop);
      cnt_in = cnt_ff + (OUTQ_AW+1)'(push_cnt) - (OUTQ_AW+1)'(pop);
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) ent_ff[wr_ff] <= push_a;
      if (push_cnt == 2'd2) ent_ff[wr_ff + OUTQ_AW'(1)] <= push_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/core/nfc_response_frame_checker_top.sv
// NFC response frame checker, top level.
// Depends on nrfc_pkg, nrfc_csr, nrfc_check and nrfc_outq.
//
// Usage:
//   req_*  : one received byte per item (req_rx_byte, req_end_of_read set on
//            the last byte of the read transaction).
//   rsp_*  : result items; a payload/identifier byte (result_kind 0) or the
//            final status (result_kind 1, is_last 1) of the transaction.
//   csr_*  : APB-style registers expect_ack (0x0), expected_code (0x4),
//            uid_only (0x8); write them only while the block is idle.
// Timing:
//   An item is registered on acceptance and checked once the result queue has
//   room; its results go through the result queue to rsp_*. One item is taken
//   per cycle while the queue has room; a byte that yields both a data result
//   and a status result puts both into the queue, the data result first.
//   The four-entry result queue sets how long the block keeps accepting while
//   the receiver stalls: it checks an item only with room for two results,
//   then req_ready drops until rsp_ready lets items drain.
// Reset: clears the transaction state, the registers (all zero) and the
//   result queue.
module nfc_response_frame_checker_top import nrfc_pkg::*; #(
   parameter int MAX_READ_BYTES = 32,
   parameter int MAX_ID_BYTES   = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_read,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_status_code,
   output logic [5:0]  rsp_payload_count,
   output logic        rsp_is_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type     cfg;
   chk_out_type chk;
   rsp_type     data_ent, stat_ent, push_a, push_b, out_item;
   logic [1:0]  push_cnt;
   logic        room;
   logic        consume;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   assign csr_pready = 1'b1;

   nrfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // Input register
   assign consume   = in_valid_ff & room;
   assign req_ready = ~in_valid_ff | consume;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (consume)           in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
         in_last_ff <= req_end_of_read;
      end
   end

   nrfc_check #(
      .MAX_READ_BYTES (MAX_READ_BYTES),
      .MAX_ID_BYTES   (MAX_ID_BYTES)
   ) u_check (
      .clock       (clock),
      .reset       (reset),
      .fire        (consume),
      .rx_byte     (in_byte_ff),
      .end_of_read (in_last_ff),
      .cfg         (cfg),
      .res         (chk)
   );

   // Form result items; a data result goes ahead of the status
   always_comb begin
      data_ent.result_kind   = 1'b0;
      data_ent.data_byte     = chk.data_byte;
      data_ent.status_code   = STATUS_OK;
      data_ent.payload_count = 6'd0;
      data_ent.is_last       = 1'b0;
      stat_ent.result_kind   = 1'b1;
      stat_ent.data_byte     = 8'd0;
      stat_ent.status_code   = chk.status_code;
      stat_ent.payload_count = chk.payload_count;
      stat_ent.is_last       = 1'b1;
      push_a   = chk.data_valid ? data_ent : stat_ent;
      push_b   = stat_ent;
      push_cnt = 2'(chk.data_valid) + 2'(chk.status_valid);
   end

   nrfc_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_a    (push_a),
      .push_b    (push_b),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (out_item)
   );

   assign rsp_result_kind   = out_item.result_kind;
   assign rsp_data_byte     = out_item.data_byte;
   assign rsp_status_code   = out_item.status_code;
   assign rsp_payload_count = out_item.payload_count;
   assign rsp_is_last       = out_item.is_last;

`ifndef NO_ASSERTIONS
   // Status items and only status items close a transaction
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_last == rsp_result_kind))
      else $error("is_last disagrees with result kind");

   // Data items carry no status and no count
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> rsp_status_code == STATUS_OK &&
      rsp_payload_count == 6'd0)
      else $error("data item with status fields set");

   // No-card status always reports an empty count
   a_nocard_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_code == STATUS_NO_CARD |-> rsp_payload_count == 6'd0)
      else $error("no-card status with nonzero count");

   // Queue comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");
`endif

endmodule

// File: test/tb.sv
// Testbench for nfc_response_frame_checker_top: reads of info, UID and ACK frames.
// A scoreboard class predicts payload and status items; tasks drive req and csr, an initial block paces rsp.
// Depends on nrfc_pkg and the top-level RTL only.
module tb;
   import nrfc_pkg::*;

   localparam int READ_MAX      = 32;
   localparam int ID_MAX        = 10;
   localparam int IDLE_LIMIT    = 5000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PHASE_ITEMS   = 75;
   localparam int RANDOM_PHASES = 10;

   // Predicts the result items of each received byte and checks the block against them
   class frame_scoreboard;
      bit         ack_mode;
      logic [7:0] resp_code;
      bit         uid_mode;

      logic [5:0] pos;
      logic [7:0] len_field;
      logic [7:0] dsum;
      bit         err;
      bit         done;
      bit         no_card;
      logic [3:0] id_len;
      logic [5:0] emitted;

      rsp_type    expected_q[$];
      int         mismatches;
      int         results_seen;

      function new();
         ack_mode = 0;
         resp_code = 8'h00;
         uid_mode = 0;
         mismatches = 0;
         results_seen = 0;
         clear_read();
      endfunction

      function void clear_read();
         pos = '0;
         len_field = '0;
         dsum = '0;
         err = 0;
         done = 0;
         no_card = 0;
         id_len = '0;
         emitted = '0;
      endfunction

      function void set_config(bit ack, logic [7:0] code, bit uid);
         ack_mode = ack;
         resp_code = code;
         uid_mode = uid;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void emit(logic [7:0] b);
         rsp_type r;
         r.result_kind = 1'b0;
         r.data_byte = b;
         r.status_code = STATUS_OK;
         r.payload_count = '0;
         r.is_last = 1'b0;
         expected_q.push_back(r);
         emitted = emitted + 6'd1;
      endfunction

      // Frame checks for the byte at position p
      function void check_byte(int p, logic [7:0] b);
         int plen;
         int q;
         plen = len_field;
         if (p == 0) begin
            if (b != READY_BYTE) err = 1;
         end else if (ack_mode) begin
            if (p <= 6) begin
               if (b != ((p == 3 || p == 5) ? START_BYTE : ZERO_BYTE)) err = 1;
               else if (p == 6) done = 1;
            end
         end else if (p == 1 || p == 2) begin
            if (b != ZERO_BYTE) err = 1;
         end else if (p == 3) begin
            if (b != START_BYTE) err = 1;
         end else if (p == 4) begin
            len_field = b;
         end else if (p == 5) begin
            if (8'(len_field + b) != 8'h00 || plen < 2 || 8 + plen > READ_MAX) err = 1;
         end else if (p == 6) begin
            if (b != DIR_BYTE) err = 1;
            else dsum = b;
         end else if (p == 7) begin
            if (b != resp_code) err = 1;
            else dsum = dsum + b;
         end else if (p < 6 + plen) begin
            dsum = dsum + b;
            if (!uid_mode) begin
               emit(b);
            end else begin
               // target list: target count, target number, two sense bytes,
               // select byte, id length, id bytes
               q = p - 8;
               if (q == 0) begin
                  if (b == 8'h00) no_card = 1;
               end else if (q == 5) begin
                  if (!no_card) begin
                     if (b == 8'h00 || b > ID_MAX) err = 1;
                     else id_len = b[3:0];
                  end
               end else if (q >= 6 && !no_card && id_len != 0 && q < 6 + id_len) begin
                  emit(b);
               end
            end
         end else if (p == 6 + plen) begin
            if (8'(dsum + b) != 8'h00) err = 1;
         end else if (p == 7 + plen) begin
            if (b != ZERO_BYTE) begin
               err = 1;
            end else begin
               done = 1;
               if (uid_mode) begin
                  if (plen - 2 < 1) err = 1;
                  else if (!no_card && (plen - 2 < 6 || 6 + id_len > plen - 2)) err = 1;
               end
            end
         end
      endfunction

      // One accepted input item
      function void note_byte(logic [7:0] b, bit last);
         int p;
         rsp_type r;
         p = pos;
         if (!err && !done) check_byte(p, b);
         if (last) begin
            r.result_kind = 1'b1;
            r.data_byte = 8'h00;
            if (err || !done) r.status_code = STATUS_FRAME;
            else if (no_card) r.status_code = STATUS_NO_CARD;
            else r.status_code = STATUS_OK;
            r.payload_count = (r.status_code == STATUS_NO_CARD) ? 6'd0 : emitted;
            r.is_last = 1'b1;
            expected_q.push_back(r);
            clear_read();
         end else if (p + 1 >= READ_MAX) begin
            err = 1;
         end else begin
            pos = 6'(p + 1);
         end
      endfunction

      // One accepted result item against the oldest prediction
      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: kind %0d data %02h status %0d count %0d last %0d",
                        got.result_kind, got.data_byte, got.status_code, got.payload_count,
                        got.is_last);
            return;
         end
         want = expected_q.pop_front();
         if (got.result_kind !== want.result_kind || got.data_byte !== want.data_byte ||
             got.status_code !== want.status_code || got.payload_count !== want.payload_count ||
             got.is_last !== want.is_last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result %0d mismatch: expected kind %0d data %02h status %0d count %0d last %0d",
                        results_seen, want.result_kind, want.data_byte, want.status_code,
                        want.payload_count, want.is_last);
               $display("   got kind %0d data %02h status %0d count %0d last %0d",
                        got.result_kind, got.data_byte, got.status_code, got.payload_count,
                        got.is_last);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        req_end_of_read;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_result_kind;
   logic [7:0]  rsp_data_byte;
   logic [1:0]  rsp_status_code;
   logic [5:0]  rsp_payload_count;
   logic        rsp_is_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   frame_scoreboard sb;
   logic [7:0]      frame_q[$];
   logic [7:0]      payload_q[$];
   bit              steady = 0;
   int              bytes_sent = 0;
   int              reads_sent = 0;
   int              settings_used = 0;

   nfc_response_frame_checker_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .req_end_of_read   (req_end_of_read),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_status_code   (rsp_status_code),
      .rsp_payload_count (rsp_payload_count),
      .rsp_is_last       (rsp_is_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #2 clock = ~clock;

   // Gap length: mostly none or short, a few long; none at all in steady stretches
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Send one byte; acceptance is decided by req_ready sampled mid-cycle
   task automatic send_byte(input logic [7:0] b, input logic last);
      int   gap;
      logic took;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_end_of_read <= last;
      took = 1'b0;
      while (!took) begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end
      sb.note_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_read();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      reads_sent++;
   endtask

   // APB setup then access; psel stays high for a following write
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
   endtask

   // Wait until the block is idle, then load all three registers
   task automatic set_mode(input bit ack, input logic [7:0] code, input bit uid);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(REG_EXPECT_ACK, {31'b0, ack});
      csr_write(REG_EXPECTED_CODE, {24'b0, code});
      csr_write(REG_UID_ONLY, {31'b0, uid});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_config(ack, code, uid);
      settings_used++;
   endtask

   // Information frame around payload_q
   function automatic void build_info(input logic [7:0] code);
      logic [7:0] len;
      logic [7:0] chk;
      logic [7:0] head [8];
      len = 8'(payload_q.size() + 2);
      chk = DIR_BYTE + code;
      head = '{READY_BYTE, ZERO_BYTE, ZERO_BYTE, START_BYTE, len, 8'(0 - len), DIR_BYTE, code};
      frame_q.delete();
      foreach (head[i]) frame_q.push_back(head[i]);
      foreach (payload_q[i]) begin
         frame_q.push_back(payload_q[i]);
         chk = chk + payload_q[i];
      end
      frame_q.push_back(8'(0 - chk));
      frame_q.push_back(ZERO_BYTE);
   endfunction

   function automatic void build_ack();
      logic [7:0] head [7];
      head = '{READY_BYTE, ZERO_BYTE, ZERO_BYTE, START_BYTE, ZERO_BYTE, START_BYTE, ZERO_BYTE};
      frame_q.delete();
      foreach (head[i]) frame_q.push_back(head[i]);
   endfunction

   // Target list with random content; sometimes no card, bad target count, bad id length, trailing bytes or cut short
   function automatic void make_target_list();
      int n;
      int r;
      payload_q.delete();
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 1) ? 0 : $urandom_range(11, 15);
      else n = $urandom_range(1, ID_MAX);
      r = $urandom_range(0, 19);
      payload_q.push_back(r < 2 ? 8'h00 : (r == 2 ? 8'($urandom_range(2, 255)) : 8'h01));
      repeat (4) payload_q.push_back(8'($urandom_range(0, 255)));
      payload_q.push_back(8'(n));
      repeat (n) payload_q.push_back(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 9);
      if (r < 2) begin
         repeat ($urandom_range(1, 3)) payload_q.push_back(8'($urandom_range(0, 255)));
      end else if (r == 2) begin
         n = $urandom_range(0, payload_q.size() - 1);
         while (payload_q.size() > n) void'(payload_q.pop_back());
      end
   endfunction

   // Break a well-formed frame: flipped byte, early end, trailing bytes or bad length
   function automatic void damage_frame();
      int k;
      case ($urandom_range(0, 3))
         0: begin
            k = $urandom_range(0, frame_q.size() - 1);
            frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
         end
         1: begin
            k = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > k) void'(frame_q.pop_back());
         end
         2: begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            frame_q[4] = $urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                              : 8'($urandom_range(0, 255));
            frame_q[5] = $urandom_range(0, 1) ? 8'(0 - frame_q[4]) : 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // One read: mostly frames for the current mode, some damaged, some noise
   task automatic random_read();
      int n;
      frame_q.delete();
      payload_q.delete();
      if ($urandom_range(0, 99) < 10) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
         repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) frame_q[0] = READY_BYTE;
      end else begin
         if (sb.ack_mode ^ ($urandom_range(0, 9) == 0)) begin
            build_ack();
         end else begin
            if (sb.uid_mode) begin
               make_target_list();
            end else begin
               n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(7, 22);
               repeat (n) payload_q.push_back(8'($urandom_range(0, 255)));
            end
            build_info(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : sb.resp_code);
         end
         if ($urandom_range(0, 99) < 35) damage_frame();
      end
      send_read();
   endtask

   // Receiver pacing: bursts of ready with random stalls between
   initial begin : rsp_pacing
      int span;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         span = steady ? 64 : $urandom_range(1, 12);
         repeat (span) @(posedge clock);
         span = pick_gap();
         if (span > 0) begin
            rsp_ready <= 1'b0;
            repeat (span) @(posedge clock);
         end
      end
   end

   // Result items are sampled mid-cycle and accepted at the next rising edge
   always @(negedge clock) begin : rsp_monitor
      rsp_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.result_kind = rsp_result_kind;
         seen.data_byte = rsp_data_byte;
         seen.status_code = status_type'(rsp_status_code);
         seen.payload_count = rsp_payload_count;
         seen.is_last = rsp_is_last;
         sb.check_result(seen);
      end
   end

   // Ends the run when nothing moves on either channel for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(negedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
      end
      $display("nfc_response_frame_checker_top regression: fail");
      $finish;
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      req_end_of_read = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty payload, extreme payload bytes, a read that ends at the ready byte
      set_mode(1'b0, 8'h00, 1'b0);
      payload_q.delete();
      build_info(8'h00);
      send_read();
      payload_q = '{8'hFF, 8'h00, 8'h80};
      build_info(8'h00);
      send_read();
      frame_q = '{READY_BYTE};
      send_read();

      // Random phases; the first ones pin the register extremes
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         int start;
         case (ph)
            0:       set_mode(1'b1, 8'hFF, 1'b0);
            1:       set_mode(1'b0, 8'hFF, 1'b1);
            2:       set_mode(1'b1, 8'h00, 1'b1);
            3:       set_mode(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            default: set_mode($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
         endcase
         steady = ($urandom_range(0, 3) == 0);
         start = bytes_sent;
         while (bytes_sent - start < PHASE_ITEMS) random_read();
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d bytes in %0d reads under %0d register settings",
               bytes_sent, reads_sent, settings_used);
      $display("%0d result items checked, %0d mismatches", sb.results_seen, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("nfc_response_frame_checker_top regression: pass");
      end else begin
         $display("nfc_response_frame_checker_top regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/nrfc_pkg.sv
rtl/core/nrfc_csr.sv
rtl/core/nrfc_check.sv
rtl/core/nrfc_outq.sv
rtl/core/nfc_response_frame_checker_top.sv
test/tb.sv
